// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, quiet during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/lrct_pkg.sv =====
`timescale 1ns / 1ps
package lrct_pkg;

   localparam int DEF_MAX_RAMPS = 16;

   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_IDLE  = 2'd2;

   localparam logic [1:0] STATUS_ADDED = 2'd0;
   localparam logic [1:0] STATUS_DUP   = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_CMP,
      ST_ADD_GO,
      ST_ADD_DIV,
      ST_EMIT,
      ST_TICK_RD,
      ST_TICK_MUL,
      ST_TICK_OUT
   } state_type;

   typedef struct packed {
      logic [7:0]  target;
      logic [31:0] start_v;
      logic [31:0] end_v;
      logic [31:0] step;
      logic [15:0] frame_now;
      logic [15:0] frame_total;
   } entry_type;

   typedef struct packed {
      logic       capture;
      logic       rd_next;
      logic       div_start;
      logic       add_write;
      logic       mul_go;
      logic       tick_out;
      logic       load_add;
      logic       load_idle;
      logic [1:0] add_status;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic full;
      logic rd_last;
      logic match;
      logic div_busy;
      logic out_free;
   } sts_type;

endpackage

// ===== design/linear_ramp_channel_table_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Payload
// req_      in         tuser: func; tdata: target, start, end, frames
// rsp_      out        tuser: kind; tdata: status, target, value, finished; tlast
//
// One request at a time. An add reads and compares each live ramp in turn; if the
// target is new and the table has room, a restoring shift-subtract divider then forms
// the step. A tick reads, multiplies and emits each live ramp in turn.
// Reset is synchronous, active high, and empties the table at once.
// A stalled response holds the walk at its current entry; nothing is dropped.
module linear_ramp_channel_table_core import lrct_pkg::*; #(
   parameter int MAX_RAMPS = DEF_MAX_RAMPS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,  // target_id[7:0], start_value[39:8],
                                   // end_value[71:40], frames[87:72]
   input  logic        req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // status[1:0], target_id_res[9:2],
                                   // value[41:10], finished[42], zero pad
   output logic [1:0]  rsp_tuser,  // kind
   output logic        rsp_tlast   // last response of this request
);
   cmd_type cmd;
   sts_type sts;

   // sequence each request
   lrct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   // ramp store, divider, multiplier and response register
   lrct_datapath #(.MAX_RAMPS(MAX_RAMPS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );
endmodule

// ===== design/lrct_div.sv =====
`timescale 1ns / 1ps
module lrct_div import lrct_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] dividend,
   input  logic [15:0]        divisor,
   output logic               busy,
   output logic [31:0]        quotient
);
   logic [32:0] quo_ff, quo_in, mag;
   logic [15:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in, zero_ff, zero_in, busy_ff, busy_in;
   logic [16:0] trial;
   logic        ge;

   assign mag   = dividend[32] ? 33'(-dividend) : dividend;
   assign trial = {rem_ff, quo_ff[32]};
   assign ge    = trial >= {1'b0, divisor};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = mag;
         rem_in  = '0;
         cnt_in  = 6'd33;
         neg_in  = dividend[32];
         zero_in = (divisor == '0);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring
         rem_in  = ge ? 16'(trial - {1'b0, divisor}) : trial[15:0];
         quo_in  = {quo_ff[31:0], ge};
         cnt_in  = cnt_ff - 6'd1;
         busy_in = (cnt_ff != 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   assign busy     = busy_ff;
   assign quotient = zero_ff ? 32'd0 : (neg_ff ? 32'(-quo_ff[31:0]) : quo_ff[31:0]);
endmodule

// ===== design/lrct_datapath.sv =====
`timescale 1ns / 1ps
module lrct_datapath import lrct_pkg::*; #(
   parameter int MAX_RAMPS = DEF_MAX_RAMPS
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output sts_type      sts,
   input  logic [87:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);
   localparam int IDXW = (MAX_RAMPS > 1) ? $clog2(MAX_RAMPS) : 1;
   localparam int CNTW = $clog2(MAX_RAMPS + 1);

   entry_type entry_mem_ff [MAX_RAMPS];
   entry_type rdata_ff, wdata;
   logic [IDXW-1:0] waddr;
   logic            wen;

   logic [7:0]  tgt_ff;
   logic [31:0] start_ff, end_ff;
   logic [15:0] frames_ff;

   logic [IDXW-1:0] rd_idx_ff, keep_ff;
   logic [CNTW-1:0] count_ff;

   logic [31:0] quotient;
   logic        div_busy;
   logic [31:0] prod_ff;
   logic [16:0] now_p1;
   logic        fin;

   logic        out_valid_ff;
   logic [1:0]  kind_ff, status_ff;
   logic [7:0]  otgt_ff;
   logic [31:0] value_ff;
   logic        ofin_ff, olast_ff;

   lrct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ($signed({end_ff[31], end_ff}) - $signed({start_ff[31], start_ff})),
      .divisor  (frames_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign now_p1 = {1'b0, rdata_ff.frame_now} + 17'd1;
   assign fin    = rdata_ff.frame_now >= rdata_ff.frame_total;

   always_comb begin
      wen   = 1'b0;
      waddr = keep_ff;
      wdata = rdata_ff;
      wdata.frame_now = now_p1[15:0];
      if (cmd.add_write) begin
         wen   = 1'b1;
         waddr = count_ff[IDXW-1:0];
         wdata = '{target: tgt_ff, start_v: start_ff, end_v: end_ff, step: quotient,
                   frame_now: 16'd0, frame_total: frames_ff};
      end else if (cmd.tick_out && !fin) begin
         wen = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wen) entry_mem_ff[waddr] <= wdata;
      rdata_ff <= entry_mem_ff[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tgt_ff    <= req_tdata[7:0];
         start_ff  <= req_tdata[39:8];
         end_ff    <= req_tdata[71:40];
         frames_ff <= req_tdata[87:72];
      end
      if (cmd.mul_go) prod_ff <= 32'(rdata_ff.step * 32'(now_p1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         keep_ff   <= '0;
         count_ff  <= '0;
      end else begin
         if (cmd.capture) begin
            rd_idx_ff <= '0;
            keep_ff   <= '0;
         end else if (cmd.rd_next) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
         if (cmd.add_write) count_ff <= count_ff + 1'b1;
         if (cmd.tick_out) begin
            if (!fin) keep_ff <= keep_ff + 1'b1;
            // close the walk: survivors are packed at the front
            if (sts.rd_last) count_ff <= CNTW'(keep_ff) + CNTW'(!fin);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_add || cmd.load_idle || cmd.tick_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.load_add) begin
         kind_ff   <= KIND_ADD;
         status_ff <= cmd.add_status;
         otgt_ff   <= tgt_ff;
         value_ff  <= '0;
         ofin_ff   <= 1'b0;
         olast_ff  <= 1'b1;
      end else if (cmd.load_idle) begin
         kind_ff   <= KIND_IDLE;
         status_ff <= STATUS_ADDED;
         otgt_ff   <= '0;
         value_ff  <= '0;
         ofin_ff   <= 1'b0;
         olast_ff  <= 1'b1;
      end else if (cmd.tick_out) begin
         kind_ff   <= KIND_VALUE;
         status_ff <= STATUS_ADDED;
         otgt_ff   <= rdata_ff.target;
         value_ff  <= fin ? rdata_ff.end_v : rdata_ff.start_v + prod_ff;
         ofin_ff   <= fin;
         olast_ff  <= sts.rd_last;
      end
   end

   assign sts.count_zero = (count_ff == '0);
   assign sts.full       = (count_ff == CNTW'(MAX_RAMPS));
   assign sts.rd_last    = (CNTW'(rd_idx_ff) + 1'b1 == count_ff);
   assign sts.match      = (rdata_ff.target == tgt_ff);
   assign sts.div_busy   = div_busy;
   assign sts.out_free   = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {5'd0, ofin_ff, value_ff, otgt_ff, status_ff};
endmodule

// ===== design/lrct_ctrl.sv =====
`timescale 1ns / 1ps
module lrct_ctrl import lrct_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  logic    req_func,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       emit_idle_ff, emit_idle_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         status_ff    <= STATUS_ADDED;
         emit_idle_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         emit_idle_ff <= emit_idle_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      emit_idle_in   = emit_idle_ff;
      cmd            = '0;
      cmd.add_status = status_ff;
      req_tready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               if (req_func == FUNC_TICK) begin
                  emit_idle_in = 1'b1;
                  state_in     = sts.count_zero ? ST_EMIT : ST_TICK_RD;
               end else begin
                  emit_idle_in = 1'b0;
                  state_in     = sts.count_zero ? ST_ADD_GO : ST_ADD_RD;
               end
            end
         end
         ST_ADD_RD: state_in = ST_ADD_CMP;
         ST_ADD_CMP: begin
            priority if (sts.match) begin
               status_in = STATUS_DUP;
               state_in  = ST_EMIT;
            end else if (!sts.rd_last) begin
               cmd.rd_next = 1'b1;
               state_in    = ST_ADD_RD;
            end else if (sts.full) begin
               status_in = STATUS_FULL;
               state_in  = ST_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_ADD_DIV;
            end
         end
         ST_ADD_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_ADD_DIV;
         end
         ST_ADD_DIV: begin
            if (!sts.div_busy) begin
               cmd.add_write = 1'b1;
               status_in     = STATUS_ADDED;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.load_idle = emit_idle_ff;
               cmd.load_add  = !emit_idle_ff;
               state_in      = ST_IDLE;
            end
         end
         ST_TICK_RD: state_in = ST_TICK_MUL;
         ST_TICK_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = ST_TICK_OUT;
         end
         ST_TICK_OUT: begin
            if (sts.out_free) begin
               cmd.tick_out = 1'b1;
               if (sts.rd_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = ST_TICK_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== design/lrct_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lrct_checker import lrct_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPL(a_kind_legal, clock, reset, rsp_tvalid, rsp_tuser <= KIND_IDLE)
   `ASSERT_IMPL(a_single_last, clock, reset, rsp_tvalid && rsp_tuser != KIND_VALUE, rsp_tlast)
endmodule

bind linear_ramp_channel_table_core lrct_checker u_lrct_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/tb_linear_ramp_channel_table_core.sv =====
`timescale 1ns / 1ps
module tb_linear_ramp_channel_table_core;
   import lrct_pkg::*;

   localparam int TABLE_DEPTH  = DEF_MAX_RAMPS;
   localparam int RANDOM_ITEMS = 385;
   localparam int CALM_FROM    = 340;   // no idling on either side from here on
   localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
   localparam int STUCK_LIMIT  = 3000;  // cycles with no handshake at all

   typedef struct {
      logic        func;
      logic [7:0]  tgt;
      logic [31:0] start_v;
      logic [31:0] end_v;
      logic [15:0] frames;
      bit          typed;      // first result is known by inspection
      logic [1:0]  want_kind;
      logic [1:0]  want_status;
   } stim_row_t;

   typedef struct {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [7:0]  tgt;
      logic [31:0] value;
      logic        fin;
      logic        last;
   } ramp_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;   // target_id, start_value, end_value, frames
   logic        req_tuser = 1'b0; // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // status, target_id_res, value, finished, pad
   logic [1:0]  rsp_tuser;        // kind
   logic        rsp_tlast;

   linear_ramp_channel_table_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the ramp table, kept in insertion order.
   logic [7:0]  ramp_tgt   [TABLE_DEPTH];
   longint      ramp_start [TABLE_DEPTH];
   longint      ramp_end   [TABLE_DEPTH];
   longint      ramp_step  [TABLE_DEPTH];
   int unsigned ramp_now   [TABLE_DEPTH];
   int unsigned ramp_total [TABLE_DEPTH];
   int          live_ramps = 0;

   ramp_rsp_t   pending_rsp[$];
   stim_row_t   directed[$];

   int  errors = 0;
   int  n_adds = 0, n_ticks = 0, n_dups = 0, n_full = 0, n_done = 0, n_rsp = 0;
   bit  calm = 0;
   bit  long_hold = 0;
   bit  typed_due = 0;
   logic [1:0] typed_kind, typed_status;
   int  stuck = 0;

   function automatic ramp_rsp_t mk_rsp(logic [1:0] kind, logic [1:0] status,
                                        logic [7:0] tgt, longint value,
                                        logic fin, logic last);
      ramp_rsp_t r;
      r.kind = kind; r.status = status; r.tgt = tgt;
      r.value = value[31:0]; r.fin = fin; r.last = last;
      return r;
   endfunction

   // Queue one response at the tail of what is still owed.
   task automatic expect_rsp(ramp_rsp_t r);
      pending_rsp.insert(pending_rsp.size(), r);
   endtask

   // Append one row to the directed table.
   task automatic stage_row(stim_row_t r);
      directed.insert(directed.size(), r);
   endtask

   // Advance the shadow table by one request and queue what it must produce.
   task automatic predict_request(logic func, logic [87:0] data);
      logic [7:0]  tgt;
      longint      s, e;
      int unsigned f;
      int          keep;
      bit          dup;
      tgt = data[7:0];
      s = longint'($signed(data[39:8]));
      e = longint'($signed(data[71:40]));
      f = data[87:72];
      keep = 0;
      dup = 0;
      if (func == FUNC_ADD) begin
         n_adds++;
         for (int i = 0; i < live_ramps; i++)
            if (ramp_tgt[i] == tgt) dup = 1;
         if (dup) begin
            n_dups++;
            expect_rsp(mk_rsp(KIND_ADD, STATUS_DUP, tgt, 0, 0, 1));
         end else if (live_ramps >= TABLE_DEPTH) begin
            n_full++;
            expect_rsp(mk_rsp(KIND_ADD, STATUS_FULL, tgt, 0, 0, 1));
         end else begin
            ramp_tgt[live_ramps]   = tgt;
            ramp_start[live_ramps] = s;
            ramp_end[live_ramps]   = e;
            ramp_step[live_ramps]  = (f != 0) ? (e - s) / longint'(f) : 0;
            ramp_now[live_ramps]   = 0;
            ramp_total[live_ramps] = f;
            live_ramps++;
            expect_rsp(mk_rsp(KIND_ADD, STATUS_ADDED, tgt, 0, 0, 1));
         end
      end else begin
         n_ticks++;
         if (live_ramps == 0)
            expect_rsp(mk_rsp(KIND_IDLE, STATUS_ADDED, 8'd0, 0, 0, 1));
         for (int i = 0; i < live_ramps; i++) begin
            if (ramp_now[i] >= ramp_total[i]) begin
               // finished ramp: emit the exact end value and drop the entry
               n_done++;
               expect_rsp(mk_rsp(KIND_VALUE, STATUS_ADDED, ramp_tgt[i],
                                 ramp_end[i], 1, i == live_ramps - 1));
            end else begin
               ramp_now[i]++;
               expect_rsp(mk_rsp(KIND_VALUE, STATUS_ADDED, ramp_tgt[i],
                                 ramp_start[i] + ramp_step[i] * ramp_now[i],
                                 0, i == live_ramps - 1));
               ramp_tgt[keep]   = ramp_tgt[i];
               ramp_start[keep] = ramp_start[i];
               ramp_end[keep]   = ramp_end[i];
               ramp_step[keep]  = ramp_step[i];
               ramp_now[keep]   = ramp_now[i];
               ramp_total[keep] = ramp_total[i];
               keep++;
            end
         end
         if (live_ramps != 0) live_ramps = keep;
      end
   endtask

   // Predict on every accepted request, then check every accepted response.
   always @(posedge clock) begin
      ramp_rsp_t want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stuck = 0;
         else stuck++;
         if (req_tvalid && req_tready) begin
            predict_request(req_tuser, req_tdata);
            // the hand-typed outcome sits at the tail of what this request adds
            if (typed_due) begin
               if (pending_rsp[pending_rsp.size() - 1].kind != typed_kind ||
                   pending_rsp[pending_rsp.size() - 1].status != typed_status) begin
                  $error("typed row: kind/status exp %0d/%0d got %0d/%0d",
                         typed_kind, typed_status,
                         pending_rsp[pending_rsp.size() - 1].kind,
                         pending_rsp[pending_rsp.size() - 1].status);
                  errors++;
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            n_rsp++;
            if (pending_rsp.size() == 0) begin
               $error("unexpected response kind %0d", rsp_tuser);
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_tuser !== want.kind) begin
                  $error("kind exp %0d got %0d", want.kind, rsp_tuser); errors++;
               end
               if (rsp_tdata[1:0] !== want.status) begin
                  $error("status exp %0d got %0d", want.status, rsp_tdata[1:0]); errors++;
               end
               if (rsp_tdata[9:2] !== want.tgt) begin
                  $error("target_id_res exp %0d got %0d", want.tgt, rsp_tdata[9:2]);
                  errors++;
               end
               if (rsp_tdata[41:10] !== want.value) begin
                  $error("value exp %0d got %0d", $signed(want.value),
                         $signed(rsp_tdata[41:10]));
                  errors++;
               end
               if (rsp_tdata[42] !== want.fin) begin
                  $error("finished exp %0d got %0d", want.fin, rsp_tdata[42]); errors++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last exp %0d got %0d", want.last, rsp_tlast); errors++;
               end
            end
         end
         if (stuck >= STUCK_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off on request, none when calm.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold = 0;
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one request and hold it until the block takes it.
   task automatic offer(stim_row_t row);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tuser    <= row.func;
      req_tdata    <= {row.frames, row.end_v, row.start_v, row.tgt};
      typed_due    <= row.typed;
      typed_kind   <= row.want_kind;
      typed_status <= row.want_status;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic stim_row_t row(logic func, logic [7:0] tgt, logic [31:0] s,
                                     logic [31:0] e, logic [15:0] f, bit typed,
                                     logic [1:0] kind, logic [1:0] status);
      stim_row_t r;
      r.func = func; r.tgt = tgt; r.start_v = s; r.end_v = e; r.frames = f;
      r.typed = typed; r.want_kind = kind; r.want_status = status;
      return r;
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return $urandom_range(0, 200) - 100;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      stim_row_t r;
      // Empty tick, extreme ramps, a duplicate, zero frames, then fill the table.
      stage_row(row(FUNC_TICK, 8'd0, 0, 0, 0, 1, KIND_IDLE, STATUS_ADDED));
      stage_row(row(FUNC_ADD, 8'd0, 32'h8000_0000, 32'h7fff_ffff, 16'd1,
                    1, KIND_ADD, STATUS_ADDED));
      stage_row(row(FUNC_ADD, 8'd0, 32'd5, 32'd9, 16'd3,
                    1, KIND_ADD, STATUS_DUP));
      stage_row(row(FUNC_ADD, 8'd255, 32'h7fff_ffff, 32'h8000_0000, 16'hffff,
                    1, KIND_ADD, STATUS_ADDED));
      stage_row(row(FUNC_ADD, 8'd7, 32'd0, 32'd100, 16'd0,
                    1, KIND_ADD, STATUS_ADDED));
      stage_row(row(FUNC_ADD, 8'd8, 32'd100, -32'sd7, 16'd3, 0, 0, 0));
      stage_row(row(FUNC_TICK, 8'd0, 0, 0, 0, 0, 0, 0));
      stage_row(row(FUNC_TICK, 8'd0, 0, 0, 0, 0, 0, 0));
      for (int t = 16; t < 30; t++)
         stage_row(row(FUNC_ADD, t[7:0], 32'(t), 32'(t * 1000 - 9000),
                       16'(t % 4), 0, 0, 0));
      stage_row(row(FUNC_ADD, 8'd255, 32'd1, 32'd2, 16'd1,
                    1, KIND_ADD, STATUS_DUP));
      stage_row(row(FUNC_ADD, 8'd200, 32'd1, 32'd2, 16'd1,
                    1, KIND_ADD, STATUS_FULL));
      stage_row(row(FUNC_TICK, 8'd0, 0, 0, 0, 0, 0, 0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) offer(directed[i]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == CALM_FROM) calm = 1;
         if (n == 120) begin
            // pause the sender until every pending response is back
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_rsp.size() != 0) @(posedge clock);
         end
         if (n == 200) long_hold = 1;   // receiver holds off, so the block stalls its input
         r = row($urandom_range(0, 99) < 55 ? FUNC_TICK : FUNC_ADD,
                 $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 31)),
                 rand_value(), rand_value(),
                 $urandom_range(0, 59) == 0 ? 16'($urandom) : 16'($urandom_range(0, 20)),
                 0, 0, 0);
         offer(r);
      end
      req_tvalid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("covered %0d adds (%0d duplicate, %0d refused full) and %0d ticks,",
               n_adds, n_dups, n_full, n_ticks);
      $display("checked %0d responses, %0d of them closing a ramp", n_rsp, n_done);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
